// ===== design/pfmc_pkg.sv =====
// ----------------------------------------------------------------------------
// Packed field match counter package
// Shared constants, register indexes, the lane-to-merge request type and the
// fields-per-word lookup.
// ----------------------------------------------------------------------------
package pfmc_pkg;

  // Width of one streamed word and the number of lanes that look at it.
  localparam int unsigned WordBits = 64;
  localparam int unsigned LaneCnt  = WordBits;
  localparam int unsigned BsW      = 6;
  localparam int unsigned CntW     = 16;
  localparam int unsigned PwW      = 7;
  localparam int unsigned McW      = 3;
  localparam int unsigned MvW      = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // Popcount grouping in the merge stage.
  localparam int unsigned GrpSize = 8;
  localparam int unsigned GrpCnt  = LaneCnt / GrpSize;
  localparam int unsigned GrpW    = $clog2(GrpSize + 1);
  localparam int unsigned SumW    = $clog2(LaneCnt + 1);

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegBitSize    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegTotalElems = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMatchCount = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMatchVal0  = 3'd3;
  localparam int unsigned        MatchRegCnt   = 4;

  // Reset values of the configuration registers.
  localparam logic [BsW-1:0]  BitSizeRst    = 6'd4;
  localparam logic [CntW-1:0] TotalElemsRst = 16'd4096;

  // Per-lane hit flags of one word, handed from the lanes to the merge stage.
  typedef struct packed {
    logic                valid;
    logic                last;
    logic [LaneCnt-1:0]  hits;
  } hit_req_t;

  // Number of whole fields that fit in one word for a given field width.
  function automatic logic [PwW-1:0] fields_per_word(input logic [BsW-1:0] bs);
    logic [PwW-1:0] pw;
    case (bs) inside
      6'd0:            pw = 7'd0;
      6'd1:            pw = 7'd64;
      6'd2:            pw = 7'd32;
      6'd3:            pw = 7'd21;
      6'd4:            pw = 7'd16;
      6'd5:            pw = 7'd12;
      6'd6:            pw = 7'd10;
      6'd7:            pw = 7'd9;
      6'd8:            pw = 7'd8;
      6'd9:            pw = 7'd7;
      6'd10:           pw = 7'd6;
      [6'd11:6'd12]:   pw = 7'd5;
      [6'd13:6'd16]:   pw = 7'd4;
      [6'd17:6'd21]:   pw = 7'd3;
      [6'd22:6'd32]:   pw = 7'd2;
      default:         pw = 7'd1;
    endcase
    return pw;
  endfunction

endpackage

// ===== design/packed_field_match_counter_top.sv =====
// The total passes the hit, group and output registers once the last word is accepted.
// Throughput: one word per cycle; all 64 lanes compare a word combinationally.
// Input stalls only while a finished total waits in the output register and the
// next last word has reached the accumulator.
// Reset: asynchronous, active low; clears the counters, the pipeline valid flags and the
// configuration registers to their defaults. No clearing pass is needed.
// ----------------------------------------------------------------------------
// Packed field match counter
// Counts fields of a streamed packed array that equal any active match value,
// with 64 parallel lanes feeding a registered popcount and accumulator.
// ----------------------------------------------------------------------------
module packed_field_match_counter_top
  import pfmc_pkg::*;
#(
  parameter int unsigned MAX_MATCH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // Word input channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [WordBits-1:0] data_word_i,
  input  logic                last_word_i,
  // Result channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [CntW-1:0]     match_total_o
);

  logic [BsW-1:0]       bit_size_q;
  logic [CntW-1:0]      total_elems_q;
  logic [McW-1:0]       match_count_q;
  logic [MvW-1:0]       match_val_q [MAX_MATCH];
  logic [MAX_MATCH-1:0] match_en;

  logic [CntW-1:0]      seen_q, seen_d;
  logic                 limit_q, limit_d;
  logic [PwW-1:0]       per_word;
  logic [CntW-1:0]      remain;
  logic [PwW-1:0]       take;
  logic [LaneCnt-1:0]   lane_en;
  logic [LaneCnt-1:0]   lane_hit;

  hit_req_t             hit_q;
  logic                 hit_valid_d;
  logic                 stall;
  logic                 in_fire;
  logic                 cfg_fire;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign in_ready_o  = !stall;
  assign in_fire     = in_valid_i && in_ready_o;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_size_q    <= BitSizeRst;
      total_elems_q <= TotalElemsRst;
      match_count_q <= '0;
    end else if (cfg_fire) begin
      if (cfg_index_i == RegBitSize) begin
        bit_size_q <= cfg_data_i[BsW-1:0];
      end
      if (cfg_index_i == RegTotalElems) begin
        total_elems_q <= cfg_data_i[CntW-1:0];
      end
      if (cfg_index_i == RegMatchCount) begin
        match_count_q <= cfg_data_i[McW-1:0];
      end
    end
  end

  // Match value registers; only the first ones have a register index.
  for (genvar k = 0; k < MAX_MATCH; k++) begin : g_mv
    if (k < MatchRegCnt) begin : g_wr
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          match_val_q[k] <= '0;
        end else if (cfg_fire && cfg_index_i == RegMatchVal0 + CfgIdxW'(k)) begin
          match_val_q[k] <= cfg_data_i[MvW-1:0];
        end
      end
    end else begin : g_fixed
      assign match_val_q[k] = '0;
    end
    assign match_en[k] = ($bits(match_count_q) + 5)'(k)
                         < {5'd0, match_count_q};
  end

  // Number of fields of this word that still fall inside the element limit.
  assign per_word = fields_per_word(bit_size_q);
  assign remain   = total_elems_q - seen_q;

  always_comb begin
    if (limit_q || bit_size_q == '0 || seen_q >= total_elems_q) begin
      take = '0;
    end else if ({{(CntW-PwW){1'b0}}, per_word} < remain) begin
      take = per_word;
    end else begin
      take = remain[PwW-1:0];
    end
    seen_d  = seen_q + {{(CntW-PwW){1'b0}}, take};
    limit_d = limit_q || (seen_d >= total_elems_q);
  end

  // Stream state: fields seen and the sticky limit flag, cleared on the last word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= '0;
      limit_q <= 1'b0;
    end else if (in_fire) begin
      seen_q  <= last_word_i ? '0 : seen_d;
      limit_q <= last_word_i ? 1'b0 : limit_d;
    end
  end

  // Parallel compare lanes.
  for (genvar j = 0; j < LaneCnt; j++) begin : g_lane
    assign lane_en[j] = PwW'(j) < take;
    pfmc_lane #(
      .LANE      (j),
      .MAX_MATCH (MAX_MATCH)
    ) u_lane (
      .word_i      (data_word_i),
      .bit_size_i  (bit_size_q),
      .lane_en_i   (lane_en[j]),
      .match_val_i (match_val_q),
      .match_en_i  (match_en),
      .hit_o       (lane_hit[j])
    );
  end

  // Hit register between the lanes and the merge tree.
  assign hit_valid_d = stall ? hit_q.valid : in_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= '0;
    end else begin
      hit_q.valid <= hit_valid_d;
      if (!stall) begin
        hit_q.last <= last_word_i;
        hit_q.hits <= lane_hit;
      end
    end
  end

  pfmc_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .hit_req_i     (hit_q),
    .stall_o       (stall),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .match_total_o (match_total_o)
  );

endmodule

// ===== design/pfmc_lane.sv =====
// ----------------------------------------------------------------------------
// Packed field match counter lane
// Extracts one field of the word at a fixed lane position and compares it
// against every active match value.
// ----------------------------------------------------------------------------
module pfmc_lane
  import pfmc_pkg::*;
#(
  parameter int unsigned LANE      = 0,
  parameter int unsigned MAX_MATCH = 4
) (
  input  logic [WordBits-1:0]  word_i,
  input  logic [BsW-1:0]       bit_size_i,
  input  logic                 lane_en_i,
  input  logic [MvW-1:0]       match_val_i [MAX_MATCH],
  input  logic [MAX_MATCH-1:0] match_en_i,
  output logic                 hit_o
);

  logic [BsW-1:0]      ofs;
  logic [WordBits-1:0] mask;
  logic [WordBits-1:0] field;
  logic [MAX_MATCH-1:0] eq;

  // Field offset is lane times width; only meaningful while the lane is enabled.
  assign ofs   = BsW'(LANE) * bit_size_i;
  assign mask  = ~({WordBits{1'b1}} << bit_size_i);
  assign field = (word_i >> ofs) & mask;

  // Compare against each match value in full width.
  always_comb begin
    for (int k = 0; k < MAX_MATCH; k++) begin
      eq[k] = match_en_i[k] && (field == {{(WordBits-MvW){1'b0}}, match_val_i[k]});
    end
  end

  assign hit_o = lane_en_i && (|eq);

endmodule

// ===== design/pfmc_merge.sv =====
// ----------------------------------------------------------------------------
// Packed field match counter merge stage
// Counts the lane hits through a registered two-level tree, accumulates the
// saturating total and holds the result request until it is taken.
// ----------------------------------------------------------------------------
module pfmc_merge
  import pfmc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  hit_req_t        hit_req_i,
  output logic            stall_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [CntW-1:0] match_total_o
);

  logic               s2_valid_q, s2_valid_d;
  logic               s2_last_q;
  logic [GrpW-1:0]    grp_q [GrpCnt];
  logic [GrpW-1:0]    grp_d [GrpCnt];
  logic [CntW-1:0]    acc_q;
  logic [SumW-1:0]    sum;
  logic [CntW:0]      tot;
  logic [CntW-1:0]    sat;
  logic               out_valid_q, out_valid_d;
  logic [CntW-1:0]    out_total_q;
  logic               emit;

  // The pipeline holds only when a finished total cannot enter the output register.
  assign stall_o = s2_valid_q && s2_last_q && out_valid_q && !out_ready_i;
  assign emit    = !stall_o && s2_valid_q && s2_last_q;

  // First tree level: popcount of each group of lanes.
  always_comb begin
    for (int g = 0; g < GrpCnt; g++) begin
      grp_d[g] = '0;
      for (int b = 0; b < GrpSize; b++) begin
        grp_d[g] = grp_d[g] + GrpW'(hit_req_i.hits[g*GrpSize+b]);
      end
    end
  end

  // Second level: sum the groups and add into the saturating total.
  always_comb begin
    sum = '0;
    for (int g = 0; g < GrpCnt; g++) begin
      sum = sum + SumW'(grp_q[g]);
    end
    tot = {1'b0, acc_q} + (CntW+1)'(sum);
    sat = tot[CntW] ? {CntW{1'b1}} : tot[CntW-1:0];
  end

  assign s2_valid_d  = stall_o ? s2_valid_q : hit_req_i.valid;
  assign out_valid_d = (out_valid_q && !out_ready_i) || emit;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
    end else begin
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
      if (!stall_o && s2_valid_q) begin
        acc_q <= s2_last_q ? '0 : sat;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (!stall_o) begin
      s2_last_q <= hit_req_i.last;
      grp_q     <= grp_d;
    end
    if (emit) begin
      out_total_q <= sat;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign match_total_o = out_total_q;

endmodule

// ===== design/pfmc_checker.sv =====
// ----------------------------------------------------------------------------
// Packed field match counter port checker
// Watches the top-level ports for result holding, input backpressure and
// reset behavior.
// ----------------------------------------------------------------------------
module pfmc_checker
  import pfmc_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input logic [CntW-1:0] match_total_o
);

  // A result request that is not taken holds its total.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(match_total_o))
    else $error("result request dropped or changed while stalled");

  // Input backpressure only comes from a result that waits to be taken.
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a waiting result");

  // No result right after reset is released.
  a_reset_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !out_valid_o)
    else $error("result request present after reset");

endmodule

bind packed_field_match_counter_top pfmc_checker u_pfmc_checker (.*);

// ===== test/tb_packed_field_match_counter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packed field match counter testbench
// Streams packed arrays through the counter under random handshake gaps and
// checks every emitted total against a cycle-free model of the counting rules
// or a typed total. A short directed table opens the run; random arrays follow.
// ----------------------------------------------------------------------------
module tb_packed_field_match_counter_top;
  import pfmc_pkg::*;

  localparam int unsigned MaxMatch = 4;
  localparam logic [CfgIdxW-1:0] RegUnmapped = 3'd7;
  localparam logic [WordBits-1:0] AllOnes = '1;

  // One line of the directed table: either a register write or a word.
  typedef enum bit {RowWord, RowWrite} row_kind_e;
  typedef struct packed {
    row_kind_e             kind;
    logic [CfgIdxW-1:0]    idx;
    logic [CfgDataW-1:0]   cdata;
    logic [WordBits-1:0]   word;
    logic                  last;
    logic                  typed;
    logic [CntW-1:0]       total;
  } row_t;

  localparam int PlanLen = 53;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [WordBits-1:0] data_word_i;
  logic                last_word_i;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [CntW-1:0]     match_total_o;

  // Configuration and running state as the counter should hold them.
  logic [BsW-1:0]  bs_cfg;
  logic [CntW-1:0] limit_cfg;
  logic [McW-1:0]  mcount_cfg;
  logic [MvW-1:0]  mval_cfg [MaxMatch];
  logic [CntW-1:0] acc_total;
  int              acc_fields;
  bit              acc_full;

  // Totals still owed by the counter, oldest first.
  logic [CntW-1:0] totals_due [$];

  int mismatches   = 0;
  int totals_seen  = 0;
  int arrays_done  = 0;
  int random_words = 0;
  int tx_idle_pct  = 0;
  int rx_idle_pct  = 0;
  int hold_reqs    = 0;
  int holds_taken  = 0;
  int stall_left   = 0;

  row_t plan [PlanLen];

  packed_field_match_counter_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_word_i  (data_word_i),
    .last_word_i  (last_word_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .match_total_o(match_total_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Counts the matching fields of one word and returns 1 when it closes an
  // array, with the finished total in tot.
  function automatic bit tally_word(input logic [WordBits-1:0] w, input bit l,
                                    output logic [CntW-1:0] tot);
    int unsigned per;
    int unsigned active;
    logic [WordBits-1:0] mask;
    logic [WordBits-1:0] field;
    bit hit;
    tot = '0;
    active = (mcount_cfg > MaxMatch) ? MaxMatch : mcount_cfg;
    if (bs_cfg != 0 && !acc_full) begin
      per = WordBits / bs_cfg;
      mask = (64'd1 << bs_cfg) - 64'd1;
      for (int j = 0; j < per; j++) begin
        if (acc_fields >= limit_cfg) break;
        field = w & mask;
        hit = 1'b0;
        for (int k = 0; k < active; k++) begin
          if (field == {32'd0, mval_cfg[k]}) hit = 1'b1;
        end
        if (hit && acc_total != 16'hFFFF) acc_total++;
        acc_fields++;
        w = w >> bs_cfg;
      end
    end
    if (acc_fields >= limit_cfg) acc_full = 1'b1;
    if (l) begin
      tot = acc_total;
      acc_total = '0;
      acc_fields = 0;
      acc_full = 1'b0;
    end
    return l;
  endfunction

  // Offers one word and waits for it to be taken; typed overrides the total.
  task automatic push_word(input logic [WordBits-1:0] w, input bit l,
                           input bit typed = 1'b0, input logic [CntW-1:0] want = '0);
    logic [CntW-1:0] tot;
    cfg_valid_i <= 1'b0;
    if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_word_i <= w;
    last_word_i <= l;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (tally_word(w, l, tot)) totals_due.push_back(typed ? want : tot);
  endtask

  // Writes one register and mirrors the write into the model state.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      RegBitSize:    bs_cfg = d[BsW-1:0];
      RegTotalElems: limit_cfg = d[CntW-1:0];
      RegMatchCount: mcount_cfg = d[McW-1:0];
      default: begin
        if (idx >= RegMatchVal0 && idx - RegMatchVal0 < MaxMatch)
          mval_cfg[idx - RegMatchVal0] = d;
      end
    endcase
  endtask

  // Stops offering requests and lets the pipeline drain completely.
  task automatic wait_quiet();
    in_valid_i  <= 1'b0;
    cfg_valid_i <= 1'b0;
    while (totals_due.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // One random array: a fresh setting of every register, then the words.
  task automatic run_array();
    int nwords;
    int per;
    int r;
    logic [BsW-1:0] bs;
    logic [CntW-1:0] tot;
    logic [MvW-1:0] mv;
    logic [WordBits-1:0] mask;
    logic [WordBits-1:0] field;
    logic [WordBits-1:0] w;
    bit l;
    wait_quiet();
    nwords = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 10);
    r = $urandom_range(0, 19);
    if (r == 0) bs = 6'd0;
    else if (r == 1) bs = 6'd1;
    else if (r == 2) bs = 6'd32;
    else if (r < 5) bs = $urandom_range(33, 63);
    else bs = $urandom_range(1, 32);
    per = (bs == 0) ? 0 : WordBits / bs;
    mask = (64'd1 << bs) - 64'd1;
    r = $urandom_range(0, 9);
    if (r == 0) tot = '0;
    else if (r == 1) tot = 16'hFFFF;
    else if (r < 6) tot = $urandom_range(0, nwords * per);
    else tot = $urandom_range(0, 65535);
    write_reg(RegBitSize, ($urandom() & ~32'h3F) | bs);
    write_reg(RegTotalElems, ($urandom() & 32'hFFFF_0000) | tot);
    write_reg(RegMatchCount, $urandom());
    for (int k = 0; k < MatchRegCnt; k++) begin
      r = $urandom_range(0, 9);
      if (r == 0) mv = '0;
      else if (r == 1) mv = '1;
      else if (r < 7) mv = $urandom() & mask[MvW-1:0];
      else mv = $urandom();
      write_reg(RegMatchVal0 + CfgIdxW'(k), mv);
    end
    if ($urandom_range(0, 3) == 0) write_reg(RegUnmapped, $urandom());

    // Most fields are planted copies of match values so that totals move.
    for (int i = 0; i < nwords; i++) begin
      w = {$urandom(), $urandom()};
      for (int j = 0; j < per; j++) begin
        if ($urandom_range(0, 99) < 60) begin
          field = {32'd0, mval_cfg[$urandom_range(0, MaxMatch - 1)]} & mask;
          if (bs > 32 && $urandom_range(0, 9) == 0)
            field = field | ({$urandom(), $urandom()} & mask);
          w = (w & ~(mask << (j * bs))) | (field << (j * bs));
        end
      end
      l = (i == nwords - 1);
      random_words++;
      push_word(w, l);
    end
    arrays_done++;
  endtask

  // Result side: random backpressure bursts plus long holds on request.
  always @(posedge clk_i) begin
    if (holds_taken != hold_reqs) begin
      holds_taken = hold_reqs;
      stall_left = 300;
    end
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else if (rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct) begin
      out_ready_i <= 1'b0;
      stall_left = $urandom_range(1, 15) - 1;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Every accepted total must match the oldest one owed.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (totals_due.size() == 0) begin
        $display("%0t: unexpected total %0d with none expected", $time, match_total_o);
        mismatches++;
      end else begin
        if (match_total_o !== totals_due[0]) begin
          $display("%0t: match_total mismatch, expected %0d, actual %0d",
                   $time, totals_due[0], match_total_o);
          mismatches++;
        end
        void'(totals_due.pop_front());
        totals_seen++;
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Timeout with %0d totals outstanding", totals_due.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    // Directed table; rows with typed totals are read straight off the rules.
    plan = '{
      '{RowWord,  RegBitSize,    32'd0, AllOnes,               1'b1, 1'b1, 16'd0},
      '{RowWrite, RegMatchCount, 32'd1, 64'd0,                 1'b0, 1'b0, 16'd0},
      '{RowWord,  RegBitSize,    32'd0, 64'd0,                 1'b1, 1'b1, 16'd16},
      '{RowWrite, RegBitSize,    32'd1, 64'd0,                 1'b0, 1'b0, 16'd0},
      '{RowWrite, RegMatchVal0,  32'd1, 64'd0,                 1'b0, 1'b0, 16'd0},
      '{RowWord,  RegBitSize,    32'd0, AllOnes,               1'b1, 1'b1, 16'd64},
      '{RowWord,  RegBitSize,    32'd0, 64'd0,                 1'b1, 1'b1, 16'd0},
      '{RowWrite, RegBitSize,    32'd0, 64'd0,                 1'b0, 1'b0, 16'd0},
      '{RowWord,  RegBitSize,    32'd0, AllOnes,               1'b1, 1'b1, 16'd0},
      '{RowWrite, RegBitSize,    32'hFFFF_FFFF, 64'd0,         1'b0, 1'b0, 16'd0},
      '{RowWrite, RegMatchVal0,  32'hFFFF_FFFF, 64'd0,         1'b0, 1'b0, 16'd0},
      '{RowWord,  RegBitSize,    32'd0, 64'h0000_0000_FFFF_FFFF, 1'b1, 1'b1, 16'd1},
      '{RowWord,  RegBitSize,    32'd0, AllOnes,               1'b1, 1'b1, 16'd0},
      '{RowWrite, RegBitSize,    32'd32, 64'd0,                1'b0, 1'b0, 16'd0},
      '{RowWrite, RegMatchCount, 32'd7, 64'd0,                 1'b0, 1'b0, 16'd0},
      '{RowWrite, RegMatchVal0,  32'd1, 64'd0,                 1'b0, 1'b0, 16'd0},
      '{RowWrite, RegMatchVal0 + 3'd1, 32'd2, 64'd0,           1'b0, 1'b0, 16'd0},
      '{RowWrite, RegMatchVal0 + 3'd2, 32'd3, 64'd0,           1'b0, 1'b0, 16'd0},
      '{RowWrite, RegMatchVal0 + 3'd3, 32'd1, 64'd0,           1'b0, 1'b0, 16'd0},
      '{RowWord,  RegBitSize,    32'd0, {32'd1, 32'd1},        1'b0, 1'b0, 16'd0},
      '{RowWord,  RegBitSize,    32'd0, {32'd3, 32'd2},        1'b0, 1'b0, 16'd0},
      '{RowWord,  RegBitSize,    32'd0, {32'd5, 32'd4},        1'b1, 1'b1, 16'd4},
      '{RowWrite, RegUnmapped,   32'hFFFF_FFFF, 64'd0,         1'b0, 1'b0, 16'd0},
      '{RowWrite, RegMatchCount, 32'd4, 64'd0,                 1'b0, 1'b0, 16'd0},
      '{RowWord,  RegBitSize,    32'd0, {32'd1, 32'hFFFF_FFFF}, 1'b1, 1'b1, 16'd1},
      '{RowWrite, RegBitSize,    32'd8, 64'd0,                 1'b0, 1'b0, 16'd0},
      '{RowWrite, RegTotalElems, 32'd10, 64'd0,                1'b0, 1'b0, 16'd0},
      '{RowWrite, RegMatchCount, 32'd1, 64'd0,                 1'b0, 1'b0, 16'd0},
      '{RowWrite, RegMatchVal0,  32'd0, 64'd0,                 1'b0, 1'b0, 16'd0},
      '{RowWord,  RegBitSize,    32'd0, 64'd0,                 1'b0, 1'b0, 16'd0},
      '{RowWord,  RegBitSize,    32'd0, 64'd0,                 1'b0, 1'b0, 16'd0},
      '{RowWrite, RegTotalElems, 32'd100, 64'd0,               1'b0, 1'b0, 16'd0},
      '{RowWord,  RegBitSize,    32'd0, 64'd0,                 1'b1, 1'b1, 16'd10},
      '{RowWrite, RegTotalElems, 32'd0, 64'd0,                 1'b0, 1'b0, 16'd0},
      '{RowWord,  RegBitSize,    32'd0, 64'd0,                 1'b1, 1'b1, 16'd0},
      '{RowWrite, RegTotalElems, 32'hFFFF, 64'd0,              1'b0, 1'b0, 16'd0},
      '{RowWrite, RegBitSize,    32'd3, 64'd0,                 1'b0, 1'b0, 16'd0},
      '{RowWrite, RegMatchCount, 32'd2, 64'd0,                 1'b0, 1'b0, 16'd0},
      '{RowWrite, RegMatchVal0,  32'd7, 64'd0,                 1'b0, 1'b0, 16'd0},
      '{RowWrite, RegMatchVal0 + 3'd1, 32'd5, 64'd0,           1'b0, 1'b0, 16'd0},
      '{RowWord,  RegBitSize,    32'd0, AllOnes,               1'b1, 1'b1, 16'd21},
      '{RowWord,  RegBitSize,    32'd0, 64'h9249_2492_4924_9249, 1'b1, 1'b0, 16'd0},
      '{RowWrite, RegBitSize,    32'd33, 64'd0,                1'b0, 1'b0, 16'd0},
      '{RowWrite, RegMatchVal0,  32'd0, 64'd0,                 1'b0, 1'b0, 16'd0},
      '{RowWord,  RegBitSize,    32'd0, 64'hFFFF_FFFE_0000_0000, 1'b1, 1'b1, 16'd1},
      '{RowWrite, RegBitSize,    32'd5, 64'd0,                 1'b0, 1'b0, 16'd0},
      '{RowWrite, RegMatchCount, 32'd3, 64'd0,                 1'b0, 1'b0, 16'd0},
      '{RowWrite, RegMatchVal0,  32'd31, 64'd0,                1'b0, 1'b0, 16'd0},
      '{RowWrite, RegMatchVal0 + 3'd1, 32'd0, 64'd0,           1'b0, 1'b0, 16'd0},
      '{RowWrite, RegMatchVal0 + 3'd2, 32'd17, 64'd0,          1'b0, 1'b0, 16'd0},
      '{RowWord,  RegBitSize,    32'd0, 64'h0123_4567_89AB_CDEF, 1'b1, 1'b0, 16'd0},
      '{RowWord,  RegBitSize,    32'd0, 64'hFEDC_BA98_7654_3210, 1'b0, 1'b0, 16'd0},
      '{RowWord,  RegBitSize,    32'd0, 64'd0,                 1'b1, 1'b0, 16'd0}
    };

    // Model state after reset.
    bs_cfg = BitSizeRst;
    limit_cfg = TotalElemsRst;
    mcount_cfg = '0;
    for (int k = 0; k < MaxMatch; k++) mval_cfg[k] = '0;
    acc_total = '0;
    acc_fields = 0;
    acc_full = 1'b0;

    rst_ni      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    data_word_i <= '0;
    last_word_i <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 20;
    rx_idle_pct = 20;
    foreach (plan[i]) begin
      if (plan[i].kind == RowWrite) begin
        wait_quiet();
        write_reg(plan[i].idx, plan[i].cdata);
      end else begin
        push_word(plan[i].word, plan[i].last, plan[i].typed, plan[i].total);
      end
    end

    // Full-scale array: one-bit fields up to the largest element count.
    wait_quiet();
    write_reg(RegBitSize, 32'd1);
    write_reg(RegTotalElems, 32'hFFFF);
    write_reg(RegMatchCount, 32'd1);
    write_reg(RegMatchVal0, 32'd1);
    repeat (1024) push_word(AllOnes, 1'b0);
    push_word(AllOnes, 1'b1, 1'b1, 16'hFFFF);

    // Random arrays; the tail of the run goes without any idling.
    while (random_words < 450) begin
      if (random_words >= 380) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else if ($urandom_range(0, 3) == 0) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else begin
        tx_idle_pct = $urandom_range(5, 60);
        rx_idle_pct = $urandom_range(5, 60);
      end
      if (hold_reqs == 0 && random_words >= 180) begin
        // Long result hold-off while single-word arrays keep coming.
        tx_idle_pct = 0;
        hold_reqs++;
        repeat (32) begin
          random_words++;
          push_word({$urandom(), $urandom()}, 1'b1);
        end
        wait_quiet();
      end
      run_array();
    end

    in_valid_i  <= 1'b0;
    cfg_valid_i <= 1'b0;
    while (totals_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Checked %0d totals from %0d random arrays (%0d random words) plus",
             totals_seen, arrays_done, random_words);
    $display("the directed table and a full-scale array, field widths 0 to 63.");
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/pfmc_pkg.sv
design/pfmc_lane.sv
design/pfmc_merge.sv
design/packed_field_match_counter_top.sv
design/pfmc_checker.sv
test/tb_packed_field_match_counter_top.sv
